@@ src/udm64_pkg.sv @@
// Shared types and constants for the unsigned 64-bit divider.
package udm64_pkg;

    localparam int DATA_WIDTH = 64;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] numerator;
        logic [DATA_WIDTH-1:0] denominator;
    } operand_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] quotient;
        logic [DATA_WIDTH-1:0] remainder;
    } result_t;

    // State passed from one cell to the next
    typedef struct packed {
        logic                  valid;
        logic                  den_zero;
        logic [DATA_WIDTH-1:0] rem;
        logic [DATA_WIDTH-1:0] quo;
        logic [DATA_WIDTH-1:0] num;
        logic [DATA_WIDTH-1:0] den;
    } stage_t;

endpackage

@@ src/udm64_cell.sv @@
// One restoring division step with its stage register.
module udm64_cell
    import udm64_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  stage_t prev,
    output stage_t cur
);

    logic                  valid_reg;
    logic                  den_zero_reg;
    logic [DATA_WIDTH-1:0] rem_reg;
    logic [DATA_WIDTH-1:0] quo_reg;
    logic [DATA_WIDTH-1:0] num_reg;
    logic [DATA_WIDTH-1:0] den_reg;

    logic [DATA_WIDTH-1:0] shifted;
    logic                  carry;
    logic                  take;
    logic [DATA_WIDTH-1:0] rem_next;
    logic [DATA_WIDTH-1:0] quo_next;
    logic [DATA_WIDTH-1:0] num_next;

    always_comb
    begin
        shifted  = {prev.rem[DATA_WIDTH-2:0], prev.num[DATA_WIDTH-1]};
        carry    = prev.rem[DATA_WIDTH-1];
        // a zero divisor never sets a quotient bit, so the numerator passes through
        take     = (carry || (shifted >= prev.den)) && !prev.den_zero;
        rem_next = take ? (shifted - prev.den) : shifted;
        quo_next = {prev.quo[DATA_WIDTH-2:0], take};
        num_next = {prev.num[DATA_WIDTH-2:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= prev.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_zero_reg <= prev.den_zero;
            rem_reg      <= rem_next;
            quo_reg      <= quo_next;
            num_reg      <= num_next;
            den_reg      <= prev.den;
        end
    end

    assign cur = '{valid:    valid_reg,
                   den_zero: den_zero_reg,
                   rem:      rem_reg,
                   quo:      quo_reg,
                   num:      num_reg,
                   den:      den_reg};

endmodule

@@ src/unsigned_divmod_64.sv @@
// Top level of the pipelined unsigned 64-bit divider.
// Unsigned 64-bit divide with remainder. One transaction enters per cycle unless
// the chain is frozen, and passes through a chain of 64 cells, each working out
// one quotient bit by restoring subtraction, followed by one output register. A
// zero divisor gives quotient 0 and remainder equal to the numerator. Stall on
// the result side while a result is held freezes the whole chain and is passed
// straight back to the operand side; empty slots in the chain are not squeezed out.
module unsigned_divmod_64
    import udm64_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     operand_valid,
    output logic     operand_stall,
    input  operand_t operand,
    output logic     result_valid,
    input  logic     result_stall,
    output result_t  result
);

    stage_t  chain [0:DATA_WIDTH];
    logic    en;
    logic    result_valid_reg;
    result_t result_reg;

    // advance whenever the output register is free or being emptied
    assign en = !result_valid_reg || !result_stall;
    assign operand_stall = !en;

    assign chain[0] = '{valid:    operand_valid,
                        den_zero: (operand.denominator == '0),
                        rem:      '0,
                        quo:      '0,
                        num:      operand.numerator,
                        den:      operand.denominator};

    for (genvar i = 0; i < DATA_WIDTH; i++)
    begin : g_cell
        udm64_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .prev  (chain[i]),
            .cur   (chain[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            result_valid_reg <= chain[DATA_WIDTH].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= '{quotient:  chain[DATA_WIDTH].quo,
                            remainder: chain[DATA_WIDTH].rem};
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // chain only holds while a finished result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        operand_stall |-> (result_valid && result_stall))
    else $error("chain held without a waiting result");

    // the last cell's transaction reaches the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (chain[DATA_WIDTH].valid && en) |=> result_valid)
    else $error("finished transaction lost");

    // a taken result with nothing behind it leaves the output empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && !chain[DATA_WIDTH].valid) |=> !result_valid)
    else $error("result repeated");

    // a non-zero divisor always leaves a remainder below it
    assert property (@(posedge clk) disable iff (!rst_n)
        (chain[DATA_WIDTH].valid && !chain[DATA_WIDTH].den_zero)
            |-> (chain[DATA_WIDTH].rem < chain[DATA_WIDTH].den))
    else $error("remainder not below divisor");

endmodule

@@ dv/unsigned_divmod_64_tb.sv @@
// Self-checking testbench for the pipelined unsigned 64-bit divider.
`timescale 1ns / 1ps

module unsigned_divmod_64_tb;
    import udm64_pkg::*;

    localparam logic [DATA_WIDTH-1:0] ALL_ONES = '1;
    localparam logic [DATA_WIDTH-1:0] TOP_BIT  = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam int PIPE_DEPTH = 65;
    localparam int RANDOM_PER_PHASE = 190;
    localparam int NUM_DIRECTED = 19;

    typedef struct packed {
        logic                  known;
        logic [DATA_WIDTH-1:0] numerator;
        logic [DATA_WIDTH-1:0] denominator;
        logic [DATA_WIDTH-1:0] quotient;
        logic [DATA_WIDTH-1:0] remainder;
    } division_case_t;

    // Quotient and remainder typed in where they are plain; zero elsewhere
    division_case_t division_cases [0:NUM_DIRECTED-1] = '{
        '{1'b1, 64'd0, 64'd0, 64'd0, 64'd0},
        '{1'b1, ALL_ONES, 64'd0, 64'd0, ALL_ONES},
        '{1'b1, 64'h1234_5678_9ABC_DEF0, 64'd0, 64'd0, 64'h1234_5678_9ABC_DEF0},
        '{1'b1, 64'd0, 64'd1, 64'd0, 64'd0},
        '{1'b1, ALL_ONES, 64'd1, ALL_ONES, 64'd0},
        '{1'b1, ALL_ONES, ALL_ONES, 64'd1, 64'd0},
        '{1'b1, 64'd0, ALL_ONES, 64'd0, 64'd0},
        '{1'b1, 64'd5, 64'd7, 64'd0, 64'd5},
        '{1'b1, ALL_ONES - 64'd1, ALL_ONES, 64'd0, ALL_ONES - 64'd1},
        '{1'b1, TOP_BIT, TOP_BIT, 64'd1, 64'd0},
        '{1'b1, ALL_ONES, 64'd2, ALL_ONES >> 1, 64'd1},
        '{1'b1, ALL_ONES, TOP_BIT, 64'd1, ALL_ONES >> 1},
        '{1'b1, 64'd100, 64'd10, 64'd10, 64'd0},
        '{1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'd2, 64'd0},
        '{1'b1, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'd0,
          64'h5555_5555_5555_5555},
        '{1'b1, ALL_ONES, 64'd3, 64'h5555_5555_5555_5555, 64'd0},
        '{1'b0, ALL_ONES, TOP_BIT | 64'd1, 64'd0, 64'd0},
        '{1'b0, TOP_BIT, 64'd3, 64'd0, 64'd0},
        '{1'b0, 64'hFEDC_BA98_7654_3210, 64'h0000_0000_0001_2345, 64'd0, 64'd0}
    };

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     operand_valid = 1'b0;
    logic     operand_stall;
    operand_t operand = '0;
    logic     result_valid;
    logic     result_stall = 1'b0;
    result_t  result;

    result_t pending_divisions [$];
    int      error_count = 0;
    int      stall_pct = 0;

    unsigned_divmod_64 DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .operand_valid (operand_valid),
        .operand_stall (operand_stall),
        .operand       (operand),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result        (result)
    );

    always #10 clk = ~clk;

    // Restoring division, most significant numerator bit first
    function automatic result_t divmod_restoring(operand_t op);
        logic [DATA_WIDTH-1:0] partial;
        logic [DATA_WIDTH-1:0] quo;
        logic                  carry;
        result_t               res;
        partial = '0;
        quo = '0;
        if (op.denominator == '0)
        begin
            res.quotient = '0;
            res.remainder = op.numerator;
            return res;
        end
        for (int i = DATA_WIDTH - 1; i >= 0; i--)
        begin
            carry = partial[DATA_WIDTH-1];
            partial = {partial[DATA_WIDTH-2:0], op.numerator[i]};
            quo = {quo[DATA_WIDTH-2:0], 1'b0};
            if (carry || partial >= op.denominator)
            begin
                partial = partial - op.denominator;
                quo[0] = 1'b1;
            end
        end
        res.quotient = quo;
        res.remainder = partial;
        return res;
    endfunction

    function automatic logic [DATA_WIDTH-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic operand_t random_operand();
        operand_t              op;
        logic [DATA_WIDTH-1:0] a;
        logic [DATA_WIDTH-1:0] b;
        op.numerator = rand_word();
        op.denominator = rand_word();
        case ($urandom_range(7))
            1: op.denominator = rand_word() >> $urandom_range(1, 63);
            2: op.denominator = '0;
            3:
            begin
                // numerator not above denominator
                a = rand_word() >> $urandom_range(0, 63);
                b = rand_word() >> $urandom_range(0, 63);
                op.numerator = (a < b) ? a : b;
                op.denominator = (a < b) ? b : a;
            end
            4: op.denominator = rand_word() | TOP_BIT;
            5:
            begin
                // exact multiple plus a small remainder
                op.denominator = (rand_word() >> $urandom_range(32, 63)) | 64'd1;
                a = rand_word() >> $urandom_range(0, 63);
                op.numerator = a * op.denominator + ($urandom % op.denominator);
            end
            6: op.denominator = 64'd1 << $urandom_range(0, 63);
            7:
            begin
                case ($urandom_range(2))
                    0: op.numerator = '0;
                    1: op.numerator = ALL_ONES;
                    default: op.numerator = TOP_BIT;
                endcase
                op.denominator = rand_word() >> $urandom_range(0, 63);
            end
            default: ;
        endcase
        return op;
    endfunction

    // Present one transaction, hold it until accepted, then log what it owes
    task automatic send_division(operand_t op, int idle_pct, result_t owed);
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            operand_valid <= 1'b0;
        end
        @(negedge clk);
        operand_valid <= 1'b1;
        operand <= op;
        do @(posedge clk); while (operand_stall);
        pending_divisions.push_back(owed);
    endtask

    task automatic run_random(int count, int idle_pct, int recv_pct);
        operand_t op;
        stall_pct = recv_pct;
        for (int n = 0; n < count; n++)
        begin
            op = random_operand();
            send_division(op, idle_pct, divmod_restoring(op));
        end
    endtask

    always @(negedge clk)
        result_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_divisions.size() == 0)
            begin
                $error("unexpected result: quotient %h remainder %h",
                       result.quotient, result.remainder);
                error_count++;
            end
            else
            begin
                want = pending_divisions.pop_front();
                if (result.quotient !== want.quotient)
                begin
                    $error("quotient: expected %h, actual %h", want.quotient,
                           result.quotient);
                    error_count++;
                end
                if (result.remainder !== want.remainder)
                begin
                    $error("remainder: expected %h, actual %h", want.remainder,
                           result.remainder);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        operand_t op;
        result_t  owed;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            op.numerator = division_cases[i].numerator;
            op.denominator = division_cases[i].denominator;
            if (division_cases[i].known)
            begin
                owed.quotient = division_cases[i].quotient;
                owed.remainder = division_cases[i].remainder;
            end
            else
                owed = divmod_restoring(op);
            send_division(op, 0, owed);
        end

        run_random(RANDOM_PER_PHASE, 0, 0);
        run_random(RANDOM_PER_PHASE, 55, 0);
        // drop valid and hold off until the pipeline has fully drained
        @(negedge clk);
        operand_valid <= 1'b0;
        while (pending_divisions.size() != 0) @(posedge clk);
        run_random(RANDOM_PER_PHASE, 0, 55);
        run_random(RANDOM_PER_PHASE, 36, 36);

        @(negedge clk);
        operand_valid <= 1'b0;
        while (pending_divisions.size() != 0) @(posedge clk);
        repeat (PIPE_DEPTH + 5) @(posedge clk);

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
